// ----- src/fdp_pkg.sv -----
package fdp_pkg;

  localparam int RAW_W = 48;
  localparam logic [31:0] CANON_NAN = 32'h7FC0_0000;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load_in;
    logic do_mul;
    logic do_add_acc;
    logic do_add_sum;
    logic rnd1;
    logic rnd2;
    logic rnd_tot;
    logic wr_mem;
    logic rd_sum;
    logic start_sum;
    logic sum_step;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic last;
    logic sum_end;
    logic out_busy;
  } sts_t;

endpackage

// ----- src/fdp_in_if.sv -----
interface fdp_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] a_element;
  logic [31:0] b_element;
  logic        last_element;

  modport source (output valid, a_element, b_element, last_element, input ready);
  modport sink (input valid, a_element, b_element, last_element, output ready);
endinterface

// ----- src/fdp_out_if.sv -----
interface fdp_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] dot_result;

  modport source (output valid, dot_result, input ready);
  modport sink (input valid, dot_result, output ready);
endinterface

// ----- src/fdp_ctrl.sv -----
module fdp_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  fdp_pkg::sts_t sts,
  output fdp_pkg::cmd_t cmd
);
  import fdp_pkg::*;

  typedef enum logic [12:0] {
    S_IDLE = 13'b0000000000001,
    S_MUL  = 13'b0000000000010,
    S_MR1  = 13'b0000000000100,
    S_MR2  = 13'b0000000001000,
    S_ADD  = 13'b0000000010000,
    S_AR1  = 13'b0000000100000,
    S_AR2  = 13'b0000001000000,
    S_WR   = 13'b0000010000000,
    S_SRD  = 13'b0000100000000,
    S_SADD = 13'b0001000000000,
    S_SR1  = 13'b0010000000000,
    S_SR2  = 13'b0100000000000,
    S_DONE = 13'b1000000000000
  } state_t;

  state_t state, state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        cmd.do_mul = 1'b1;
        state_next = S_MR1;
      end
      S_MR1: begin
        cmd.rnd1 = 1'b1;
        state_next = S_MR2;
      end
      S_MR2: begin
        cmd.rnd2 = 1'b1;
        state_next = S_ADD;
      end
      S_ADD: begin
        cmd.do_add_acc = 1'b1;
        state_next = S_AR1;
      end
      S_AR1: begin
        cmd.rnd1 = 1'b1;
        state_next = S_AR2;
      end
      S_AR2: begin
        cmd.rnd2 = 1'b1;
        state_next = S_WR;
      end
      S_WR: begin
        cmd.wr_mem = 1'b1;
        if (sts.last) begin
          cmd.start_sum = 1'b1;
          state_next = S_SRD;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_SRD: begin
        cmd.rd_sum = 1'b1;
        state_next = S_SADD;
      end
      S_SADD: begin
        cmd.do_add_sum = 1'b1;
        state_next = S_SR1;
      end
      S_SR1: begin
        cmd.rnd1 = 1'b1;
        state_next = S_SR2;
      end
      S_SR2: begin
        cmd.rnd2 = 1'b1;
        cmd.rnd_tot = 1'b1;
        cmd.sum_step = 1'b1;
        state_next = sts.sum_end ? S_DONE : S_SRD;
      end
      S_DONE: begin
        if (!sts.out_busy) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  a_accept_mul: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> state == S_MUL)
    else $error("accepted request did not start multiply");

  a_finish_free: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> !sts.out_busy)
    else $error("result loaded over a pending one");

  a_sum_follows: assert property (@(posedge clk) disable iff (rst)
    (state == S_WR && sts.last) |=> state == S_SRD)
    else $error("last request did not start final sum");

endmodule

// ----- src/fdp_datapath.sv -----
module fdp_datapath #(
  parameter int LANES = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  fdp_pkg::cmd_t cmd,
  output fdp_pkg::sts_t sts,
  input  logic [31:0]   a_element,
  input  logic [31:0]   b_element,
  input  logic          last_element,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [31:0]   dot_result
);
  import fdp_pkg::*;

  localparam int LW = (LANES > 1) ? $clog2(LANES) : 1;
  localparam logic [LW-1:0] LAST_LANE = LW'(LANES - 1);

  logic [31:0] a_q, b_q, res, tot, rdata;
  logic        last_q, part_ok;
  logic [LW-1:0] lane, sidx;
  logic [LANES-1:0] valid_q;
  logic [31:0] mem [LANES];

  // unrounded value: sig * 2^(q - 150)
  logic [RAW_W-1:0] raw_sig;
  logic signed [10:0] raw_q;
  logic raw_sign, raw_spec;
  logic [31:0] raw_spec_val;
  logic signed [11:0] shamt;

  logic [31:0] part;
  assign part = part_ok ? rdata : 32'h0;

  // multiply, unrounded
  logic [7:0]  ma_e, mb_e;
  logic [23:0] ma_m, mb_m;
  logic        ma_nan, mb_nan, ma_inf, mb_inf, ma_zero, mb_zero;
  logic [RAW_W-1:0] mul_sig;
  logic signed [10:0] mul_q;
  always_comb begin
    ma_e = a_q[30:23];
    mb_e = b_q[30:23];
    ma_m = {|ma_e, a_q[22:0]};
    mb_m = {|mb_e, b_q[22:0]};
    ma_nan = (&ma_e) && (|a_q[22:0]);
    mb_nan = (&mb_e) && (|b_q[22:0]);
    ma_inf = (&ma_e) && !(|a_q[22:0]);
    mb_inf = (&mb_e) && !(|b_q[22:0]);
    ma_zero = (a_q[30:0] == 31'h0);
    mb_zero = (b_q[30:0] == 31'h0);
    mul_sig = ma_m * mb_m;
    mul_q = $signed({3'b0, (|ma_e) ? ma_e : 8'd1}) + $signed({3'b0, (|mb_e) ? mb_e : 8'd1})
            - 11'sd150;
  end

  // add, unrounded
  logic [31:0] ax, ay, big, sml;
  logic [7:0]  eb, es, dd;
  logic [4:0]  dcl;
  logic [26:0] ext_s, sh, bgx, smx;
  logic        lost, esub, ax_nan, ay_nan, ax_inf, ay_inf;
  logic [27:0] sum28;
  always_comb begin
    ax = cmd.do_add_sum ? tot : part;
    ay = cmd.do_add_sum ? part : res;
    if (ax[30:0] >= ay[30:0]) begin
      big = ax;
      sml = ay;
    end else begin
      big = ay;
      sml = ax;
    end
    eb = (|big[30:23]) ? big[30:23] : 8'd1;
    es = (|sml[30:23]) ? sml[30:23] : 8'd1;
    dd = eb - es;
    dcl = (dd > 8'd27) ? 5'd27 : dd[4:0];
    ext_s = {|sml[30:23], sml[22:0], 3'b0};
    bgx = {|big[30:23], big[22:0], 3'b0};
    sh = ext_s >> dcl;
    lost = ((sh << dcl) != ext_s);
    smx = {sh[26:1], sh[0] | lost};
    esub = ax[31] ^ ay[31];
    sum28 = esub ? ({1'b0, bgx} - {1'b0, smx}) : ({1'b0, bgx} + {1'b0, smx});
    ax_nan = (&ax[30:23]) && (|ax[22:0]);
    ay_nan = (&ay[30:23]) && (|ay[22:0]);
    ax_inf = (&ax[30:23]) && !(|ax[22:0]);
    ay_inf = (&ay[30:23]) && !(|ay[22:0]);
  end

  // leading one position and shift amount
  logic [5:0] msb;
  logic signed [11:0] s_a, s_b;
  always_comb begin
    msb = '0;
    for (int i = 0; i < RAW_W; i++) begin
      if (raw_sig[i]) msb = 6'(i);
    end
    s_a = $signed({6'b0, msb}) - 12'sd23;
    s_b = 12'sd1 - $signed({raw_q[10], raw_q});
  end

  // shift, round to nearest even, pack
  logic [97:0] wide;
  logic [5:0]  scl;
  logic [4:0]  nsh;
  logic [23:0] m24, mf;
  logic [24:0] mr;
  logic        g, st, up;
  logic signed [11:0] ee;
  logic [31:0] rounded;
  always_comb begin
    scl = (shamt > 12'sd50) ? 6'd50 : shamt[5:0];
    nsh = 5'(-shamt);
    wide = {raw_sig, 50'b0} >> scl;
    if (shamt < 0) begin
      m24 = 24'(raw_sig << nsh);
      g = 1'b0;
      st = 1'b0;
    end else begin
      m24 = wide[73:50];
      g = wide[49];
      st = |wide[48:0];
    end
    up = g & (st | m24[0]);
    mr = {1'b0, m24} + {24'b0, up};
    ee = $signed({raw_q[10], raw_q}) + shamt;
    if (mr[24]) begin
      mf = mr[24:1];
      ee = ee + 12'sd1;
    end else begin
      mf = mr[23:0];
    end
    if (raw_spec) begin
      rounded = raw_spec_val;
    end else if (raw_sig == '0) begin
      rounded = {raw_sign, 31'h0};
    end else if (ee >= 12'sd255) begin
      rounded = {raw_sign, 8'hFF, 23'h0};
    end else begin
      rounded = {raw_sign, mf[23] ? ee[7:0] : 8'h0, mf[22:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      a_q <= a_element;
      b_q <= b_element;
      last_q <= last_element;
    end
    if (cmd.do_mul) begin
      raw_sig <= mul_sig;
      raw_q <= mul_q;
      raw_sign <= a_q[31] ^ b_q[31];
      raw_spec <= ma_nan | mb_nan | ma_inf | mb_inf;
      raw_spec_val <= (ma_nan | mb_nan | (ma_inf & mb_zero) | (mb_inf & ma_zero)) ?
                      CANON_NAN : {a_q[31] ^ b_q[31], 8'hFF, 23'h0};
    end
    if (cmd.do_add_acc || cmd.do_add_sum) begin
      raw_sig <= {20'b0, sum28};
      raw_q <= $signed({3'b0, eb}) - 11'sd3;
      raw_sign <= (sum28 == 28'h0) ? (ax[31] & ay[31]) : big[31];
      raw_spec <= ax_nan | ay_nan | ax_inf | ay_inf;
      raw_spec_val <= (ax_nan | ay_nan | (ax_inf & ay_inf & esub)) ?
                      CANON_NAN : {ax_inf ? ax[31] : ay[31], 8'hFF, 23'h0};
    end
    if (cmd.rnd1) shamt <= (s_a > s_b) ? s_a : s_b;
    if (cmd.rnd2) begin
      if (cmd.rnd_tot) tot <= rounded;
      else res <= rounded;
    end
    if (cmd.start_sum) tot <= 32'h0;
    if (cmd.wr_mem) mem[lane] <= res;
    if (cmd.load_in || cmd.rd_sum) rdata <= mem[cmd.rd_sum ? sidx : lane];
    if (cmd.finish) dot_result <= tot;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= '0;
      lane <= '0;
      sidx <= '0;
      part_ok <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.load_in || cmd.rd_sum) part_ok <= valid_q[cmd.rd_sum ? sidx : lane];
      if (cmd.wr_mem) begin
        valid_q[lane] <= 1'b1;
        lane <= (lane == LAST_LANE) ? '0 : lane + 1'b1;
      end
      if (cmd.start_sum) sidx <= '0;
      if (cmd.sum_step) sidx <= sidx + 1'b1;
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (cmd.finish) begin
        out_valid <= 1'b1;
        valid_q <= '0;
        lane <= '0;
      end
    end
  end

  assign sts.last = last_q;
  assign sts.sum_end = (sidx == LAST_LANE);
  assign sts.out_busy = out_valid;

endmodule

// ----- src/float_dot_product_interleaved_unit.sv -----
// A pair is accepted only in the idle state, so the next pair waits until the current one has
// been multiplied, added to its lane's partial sum and written back. A pair marked last then
// starts the in-order sweep of all lanes (read, add, round per lane) before its result is valid.
// Pairs go through the shared multiply/add/round sequence one at a time.
// The result register lets a new vector start while a finished result waits.
// Reset (rst, synchronous, active high) clears the controller, lane counter,
// lane valid bits (partials read as +0) and the output valid.
module float_dot_product_interleaved_unit #(
  parameter int LANES = 16
) (
  input logic clk,
  input logic rst,
  fdp_in_if.sink    in_ch,
  fdp_out_if.source out_ch
);
  import fdp_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Controller: one-hot sequencer stepping multiply, round, accumulate,
  // write-back and, on the last request, the in-order sweep of all lanes.
  // The sweep holds in its final state while an earlier result still waits.
  fdp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Datapath: float multiply, float add, shared normalize/round,
  // partial-sum memory with per-lane valid bits, output register.
  fdp_datapath #(
    .LANES (LANES)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .a_element    (in_ch.a_element),
    .b_element    (in_ch.b_element),
    .last_element (in_ch.last_element),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .dot_result   (out_ch.dot_result)
  );

endmodule
